// File: design/smr_pkg.sv
// smr_pkg: mode and status codes for the signed modulo block
// no dependencies; used by the interfaces and all modules
`timescale 1ns / 1ps
`default_nettype none

package smr_pkg;

    localparam int CMD_WIDTH    = 4;
    localparam int STATUS_WIDTH = 2;

    typedef logic [CMD_WIDTH-1:0]    cmd_t;
    typedef logic [STATUS_WIDTH-1:0] status_t;

    localparam cmd_t MODE_CEIL       = 4'd0;
    localparam cmd_t MODE_FLOOR      = 4'd1;
    localparam cmd_t MODE_AWAY       = 4'd2;
    localparam cmd_t MODE_TRUNC      = 4'd3;
    localparam cmd_t MODE_NEAR_UP    = 4'd4;
    localparam cmd_t MODE_NEAR_DOWN  = 4'd5;
    localparam cmd_t MODE_NEAR_AWAY  = 4'd6;
    localparam cmd_t MODE_NEAR_ZERO  = 4'd7;
    localparam cmd_t MODE_EUCLID     = 4'd8;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_DIV_ZERO = 2'd1;
    localparam status_t STATUS_BAD_MODE = 2'd2;

endpackage

`default_nettype wire

// File: design/smr_op_if.sv
// smr_op_if: operand channel, one beat carries mode, dividend and divisor
// depends on smr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface smr_op_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                          valid;
    logic                          ready;
    logic [smr_pkg::CMD_WIDTH-1:0] cmd;
    logic signed [DATA_WIDTH-1:0]  dividend;
    logic signed [DATA_WIDTH-1:0]  divisor;

    modport source (output valid, output cmd, output dividend, output divisor, input ready);
    modport sink   (input valid, input cmd, input dividend, input divisor, output ready);
endinterface

`default_nettype wire

// File: design/smr_res_if.sv
// smr_res_if: result channel, one beat carries remainder and status
// depends on smr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface smr_res_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                             valid;
    logic                             ready;
    logic signed [DATA_WIDTH-1:0]     remainder;
    logic [smr_pkg::STATUS_WIDTH-1:0] status;

    modport source (output valid, output remainder, output status, input ready);
    modport sink   (input valid, input remainder, input status, output ready);
endinterface

`default_nettype wire

// File: design/signed_modulo_rounding_modes.sv
// signed_modulo_rounding_modes: pipelined signed modulo with eight rounding modes
// and a euclidean mode; depends on smr_pkg, smr_op_if, smr_res_if
//
//   channel | dir | beat contents
//   op      | in  | cmd, dividend, divisor
//   res     | out | remainder, status
//
// pipeline stages: one input stage, one restoring divider stage
// per dividend bit, one rounding stage and the output register
// one beat per cycle is accepted; every stage holds when the one after it is full
// and stalled, and empty stages fill while the output waits
// rst_n clears the valid bits only
`timescale 1ns / 1ps
`default_nettype none

module signed_modulo_rounding_modes #(
    parameter int DATA_WIDTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    smr_op_if.sink    op,
    smr_res_if.source res
);
    import smr_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int FS = W + 1;
    localparam int OS = W + 2;
    localparam int NS = W + 3;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] stage_ready;

    cmd_t          mode_reg [0:W];
    logic          aneg_reg [0:W];
    logic          bneg_reg [0:W];
    status_t       stat_reg [0:W];
    logic [W-1:0]  bmag_reg [0:W];
    logic [W-1:0]  num_reg  [0:W];
    logic [W-1:0]  rem_reg  [0:W];

    logic [W-1:0]  mag_reg;
    logic          rneg_reg;
    status_t       fstat_reg;
    logic [W-1:0]  remainder_reg;
    status_t       status_reg;

    // ready chain, back to front
    assign stage_ready[NS-1] = !valid_reg[NS-1] || res.ready;
    genvar g;
    generate
        for (g = 0; g < NS - 1; g++)
        begin : g_ready
            assign stage_ready[g] = !valid_reg[g] || stage_ready[g+1];
        end
    endgenerate

    assign op.ready = stage_ready[0];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= op.valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (stage_ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // input stage: magnitudes and error status
    logic [W-1:0] amag_next;
    logic [W-1:0] bmag_next;
    status_t      stat_next;

    always_comb
    begin
        amag_next = op.dividend[W-1] ? $unsigned(-op.dividend) : $unsigned(op.dividend);
        bmag_next = op.divisor[W-1] ? $unsigned(-op.divisor) : $unsigned(op.divisor);
        if (op.cmd > MODE_EUCLID)
        begin
            stat_next = STATUS_BAD_MODE;
        end
        else if (op.divisor == '0)
        begin
            stat_next = STATUS_DIV_ZERO;
        end
        else
        begin
            stat_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0] && op.valid)
        begin
            mode_reg[0] <= op.cmd;
            aneg_reg[0] <= op.dividend[W-1];
            bneg_reg[0] <= op.divisor[W-1];
            stat_reg[0] <= stat_next;
            bmag_reg[0] <= bmag_next;
            num_reg[0]  <= amag_next;
            rem_reg[0]  <= '0;
        end
    end

    // restoring divider, one dividend bit per stage
    generate
        for (g = 1; g <= W; g++)
        begin : g_div
            logic [W:0]   trial;
            logic [W:0]   diff;
            logic [W-1:0] rem_next;

            always_comb
            begin
                trial    = {rem_reg[g-1], num_reg[g-1][W-1]};
                diff     = trial - {1'b0, bmag_reg[g-1]};
                rem_next = diff[W] ? trial[W-1:0] : diff[W-1:0];
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[g] && valid_reg[g-1])
                begin
                    mode_reg[g] <= mode_reg[g-1];
                    aneg_reg[g] <= aneg_reg[g-1];
                    bneg_reg[g] <= bneg_reg[g-1];
                    stat_reg[g] <= stat_reg[g-1];
                    bmag_reg[g] <= bmag_reg[g-1];
                    num_reg[g]  <= {num_reg[g-1][W-2:0], 1'b0};
                    rem_reg[g]  <= rem_next;
                end
            end
        end
    endgenerate

    // rounding stage: pick truncated or away-from-zero remainder
    logic [W-1:0] rest;
    logic         qpos;
    logic         gt;
    logic         tie;
    logic         away;
    logic [W-1:0] mag_next;
    logic         rneg_next;

    always_comb
    begin
        rest = bmag_reg[W] - rem_reg[W];
        qpos = (aneg_reg[W] == bneg_reg[W]);
        gt   = rem_reg[W] > rest;
        tie  = rem_reg[W] == rest;
        unique case (mode_reg[W])
            MODE_CEIL:      away = qpos;
            MODE_FLOOR:     away = !qpos;
            MODE_AWAY:      away = 1'b1;
            MODE_TRUNC:     away = 1'b0;
            MODE_NEAR_UP:   away = gt || (tie && qpos);
            MODE_NEAR_DOWN: away = gt || (tie && !qpos);
            MODE_NEAR_AWAY: away = gt || tie;
            MODE_NEAR_ZERO: away = gt;
            MODE_EUCLID:    away = aneg_reg[W];
            default:        away = 1'b0;
        endcase
        if (rem_reg[W] == '0)
        begin
            away = 1'b0;
        end
        mag_next  = away ? rest : rem_reg[W];
        rneg_next = away ? !aneg_reg[W] : aneg_reg[W];
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[FS] && valid_reg[FS-1])
        begin
            mag_reg   <= mag_next;
            rneg_reg  <= rneg_next;
            fstat_reg <= stat_reg[W];
        end
    end

    // output register: apply sign, zero on error
    logic [W-1:0] remainder_next;

    always_comb
    begin
        if (fstat_reg != STATUS_OK)
        begin
            remainder_next = '0;
        end
        else if (rneg_reg)
        begin
            remainder_next = ~mag_reg + 1'b1;
        end
        else
        begin
            remainder_next = mag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[OS] && valid_reg[OS-1])
        begin
            remainder_reg <= remainder_next;
            status_reg    <= fstat_reg;
        end
    end

    assign res.valid     = valid_reg[OS];
    assign res.remainder = $signed(remainder_reg);
    assign res.status    = status_reg;

endmodule

`default_nettype wire

// File: design/smr_checker.sv
// smr_checker: port-level assertions for signed_modulo_rounding_modes
// depends on smr_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module smr_checker #(
    parameter int DATA_WIDTH = 16
) (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             op_ready,
    input wire logic                             res_valid,
    input wire logic                             res_ready,
    input wire logic [DATA_WIDTH-1:0]            res_remainder,
    input wire logic [smr_pkg::STATUS_WIDTH-1:0] res_status
);
    import smr_pkg::*;

    // a result beat never carries an unused status code
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_status == STATUS_OK || res_status == STATUS_DIV_ZERO
                       || res_status == STATUS_BAD_MODE))
    else $error("smr: undefined status code");

    // an error beat has a zero remainder
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_status != STATUS_OK) |-> (res_remainder == '0))
    else $error("smr: nonzero remainder on error");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_remainder)
                                       && $stable(res_status)))
    else $error("smr: stalled result changed");

    // with the sink ready the pipeline never pushes back
    assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> op_ready)
    else $error("smr: operand channel stalled with result sink ready");

endmodule

bind signed_modulo_rounding_modes smr_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_smr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .op_ready      (op.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_remainder (res.remainder),
    .res_status    (res.status)
);

`default_nettype wire

// File: verif/tb_signed_modulo_rounding_modes.sv
// tb_signed_modulo_rounding_modes: self-checking bench for the signed modulo block
// depends on smr_pkg, smr_op_if, smr_res_if and signed_modulo_rounding_modes;
// predicts each remainder in a scoreboard class and drives random traffic with stalls
`timescale 1ns / 1ps

module tb_signed_modulo_rounding_modes;

    import smr_pkg::*;

    localparam int DW          = 16;
    localparam int LATENCY     = DW + 3;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef logic signed [DW-1:0] word_t;

    typedef struct packed {
        word_t   remainder;
        status_t status;
    } mod_result_t;

    class remainder_scoreboard;
        mod_result_t expected_q[$];
        int operand_beats;
        int result_beats;
        int errors;
        int zero_div_seen;
        int bad_mode_seen;

        function mod_result_t predict(cmd_t mode, word_t a, word_t b);
            logic [DW-1:0] amag;
            logic [DW-1:0] bmag;
            logic [DW-1:0] rm;
            logic [DW-1:0] rest;
            logic [DW-1:0] mag;
            bit            aneg;
            bit            bneg;
            bit            qpos;
            bit            gt;
            bit            tie;
            bit            away;
            bit            rneg;
            mod_result_t   r;
            r.remainder = '0;
            r.status    = STATUS_OK;
            if (mode > MODE_EUCLID)
            begin
                r.status = STATUS_BAD_MODE;
                return r;
            end
            if (b == 0)
            begin
                r.status = STATUS_DIV_ZERO;
                return r;
            end
            aneg = a[DW-1];
            bneg = b[DW-1];
            amag = aneg ? (~a + 1'b1) : a;
            bmag = bneg ? (~b + 1'b1) : b;
            rm   = amag % bmag;
            rest = bmag - rm;
            qpos = (aneg == bneg);
            gt   = rm > rest;
            tie  = rm == rest;
            case (mode)
                MODE_CEIL:      away = qpos;
                MODE_FLOOR:     away = !qpos;
                MODE_AWAY:      away = 1'b1;
                MODE_TRUNC:     away = 1'b0;
                MODE_NEAR_UP:   away = gt || (tie && qpos);
                MODE_NEAR_DOWN: away = gt || (tie && !qpos);
                MODE_NEAR_AWAY: away = gt || tie;
                MODE_NEAR_ZERO: away = gt;
                default:        away = aneg;  // euclidean: remainder is never negative
            endcase
            if (rm == 0)
                away = 1'b0;
            if (away)
            begin
                mag  = rest;
                rneg = !aneg;
            end
            else
            begin
                mag  = rm;
                rneg = aneg;
            end
            r.remainder = rneg ? (~mag + 1'b1) : mag;
            return r;
        endfunction

        function void note_error(string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $realtime, what);
        endfunction

        function void note_operands(cmd_t mode, word_t a, word_t b);
            expected_q.push_back(predict(mode, a, b));
            operand_beats++;
        endfunction

        function void check_result(word_t rem, status_t st);
            mod_result_t want;
            result_beats++;
            if (st == STATUS_DIV_ZERO)
                zero_div_seen++;
            if (st == STATUS_BAD_MODE)
                bad_mode_seen++;
            if (expected_q.size() == 0)
            begin
                note_error($sformatf("result beat with nothing pending: remainder %0d status %0d",
                                     rem, st));
                return;
            end
            want = expected_q.pop_front();
            if (want.remainder !== rem || want.status !== st)
                note_error($sformatf("beat %0d expected remainder %0d status %0d, got %0d / %0d",
                                     result_beats, want.remainder, want.status, rem, st));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   no_gaps  = 1'b0;
    bit   hold_req = 1'b0;
    int   idle_cycles = 0;

    remainder_scoreboard rem_check = new();

    smr_op_if  #(.DATA_WIDTH(DW)) op_bus ();
    smr_res_if #(.DATA_WIDTH(DW)) res_bus ();

    signed_modulo_rounding_modes #(
        .DATA_WIDTH(DW)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op_bus),
        .res   (res_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && op_bus.valid && op_bus.ready)
            rem_check.note_operands(op_bus.cmd, op_bus.dividend, op_bus.divisor);
        if (rst_n === 1'b1 && res_bus.valid && res_bus.ready)
            rem_check.check_result(res_bus.remainder, res_bus.status);
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (op_bus.valid && op_bus.ready) || (res_bus.valid && res_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles, %0d results pending",
                     idle_cycles, rem_check.pending());
            $display("** signed_modulo_rounding_modes: FAILED **");
            $finish;
        end
    end

    // result side: random back-pressure, calm stretches and one long hold-off
    initial
    begin
        res_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            res_bus.ready <= no_gaps || ($urandom_range(99) >= 20);
        end
    end

    task automatic send_beat(input cmd_t mode, input word_t a, input word_t b);
        if (!no_gaps && $urandom_range(99) < 25)
        begin
            op_bus.valid <= 1'b0;
            @(negedge clk);
        end
        op_bus.valid    <= 1'b1;
        op_bus.cmd      <= mode;
        op_bus.dividend <= a;
        op_bus.divisor  <= b;
        @(posedge clk);
        while (!op_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_beat();
        cmd_t mode;
        int   a;
        int   b;
        int   q;
        int   pick;
        int   sgn;
        pick = $urandom_range(99);
        if (pick < 10)
            mode = cmd_t'($urandom_range(15, 9));
        else
            mode = cmd_t'($urandom_range(8, 0));
        sgn  = ($urandom_range(1) == 1) ? -1 : 1;
        pick = $urandom_range(99);
        if (pick < 4)
            b = 0;
        else if (pick < 35)
            b = sgn * int'($urandom_range(16, 1));
        else if (pick < 45)
        begin
            case ($urandom_range(3))
                0:       b = -32768;
                1:       b = 32767;
                2:       b = -1;
                default: b = 1;
            endcase
        end
        else
            b = int'(word_t'($urandom));
        q    = int'($urandom_range(200)) - 100;
        pick = $urandom_range(99);
        if (pick < 20 && b != 0 && b % 2 == 0)
            a = q * b + b / 2;  // half-way case
        else if (pick < 30)
        begin
            case ($urandom_range(3))
                0:       a = -32768;
                1:       a = 32767;
                2:       a = -1;
                default: a = 0;
            endcase
        end
        else if (pick < 40)
            a = q * b;
        else
            a = int'(word_t'($urandom));
        send_beat(mode, DW'(a), DW'(b));
    endtask

    task automatic wait_drained();
        op_bus.valid <= 1'b0;
        while (rem_check.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        op_bus.valid    = 1'b0;
        op_bus.cmd      = MODE_CEIL;
        op_bus.dividend = '0;
        op_bus.divisor  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every mode on a negative tie, nearest modes on a positive tie
        for (int m = MODE_CEIL; m <= MODE_EUCLID; m++)
            send_beat(cmd_t'(m), -7, 2);
        for (int m = MODE_NEAR_UP; m <= MODE_NEAR_ZERO; m++)
            send_beat(cmd_t'(m), 7, 2);
        send_beat(MODE_FLOOR, -32768, -1);
        send_beat(MODE_EUCLID, -32768, 32767);
        send_beat(MODE_CEIL, 32767, -32768);
        send_beat(MODE_NEAR_AWAY, -32768, -32768);
        send_beat(MODE_TRUNC, 12, 0);
        send_beat(cmd_t'(9), 5, 0);  // bad mode wins over zero divisor
        send_beat(cmd_t'(15), -1, 3);
        send_beat(MODE_AWAY, 0, 5);
        send_beat(MODE_EUCLID, -9, -4);
        send_beat(MODE_NEAR_UP, 32767, 32767);
        send_beat(MODE_NEAR_DOWN, -32767, 2);

        repeat (600) random_beat();

        // no idling on either side
        no_gaps = 1'b1;
        repeat (300) random_beat();
        no_gaps = 1'b0;

        // receiver holds off while operands keep coming, then sender waits for all
        hold_req = 1'b1;
        repeat (80) random_beat();
        wait_drained();

        repeat (520) random_beat();
        op_bus.valid <= 1'b0;

        while (rem_check.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("covered %0d operand beats over all nine modes and bad codes, %0d results checked",
                 rem_check.operand_beats, rem_check.result_beats);
        $display("%0d zero-divisor and %0d bad-mode results, %0d mismatches, %0d left pending",
                 rem_check.zero_div_seen, rem_check.bad_mode_seen, rem_check.errors,
                 rem_check.pending());
        if (rem_check.errors == 0 && rem_check.pending() == 0)
            $display("** signed_modulo_rounding_modes: PASSED **");
        else
            $display("** signed_modulo_rounding_modes: FAILED **");
        $finish;
    end

endmodule
